/* sv/htfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_pkg
// Shared types, constants and the crc-8 byte update of the frame checker.
// ----------------------------------------------------------------------------
package htfc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions within a frame
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUMI_HI  = 3'd3;
  localparam logic [2:0] POS_HUMI_LO  = 3'd4;
  localparam logic [2:0] POS_HUMI_CRC = 3'd5;

  // conversion constants, centi units
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [16:0] TEMP_OFFSET = 17'd4500;
  localparam logic [14:0] HUMI_SCALE  = 15'd12500;
  localparam logic [16:0] HUMI_OFFSET = 17'd600;

  typedef struct packed {
    logic [15:0] temp_ticks;
    logic [15:0] humi_ticks;
    logic        temp_ok;
    logic        humi_ok;
  } htfc_result_t;

  // one byte through the crc, msb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/htfc_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_frame
// Frame position tracking, crc check and storage of the last good words.
// ----------------------------------------------------------------------------
module htfc_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  output logic                  done_o,
  output htfc_pkg::htfc_result_t result_o
);
  import htfc_pkg::*;

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  hi_q, hi_d, lo_q, lo_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_q, temp_d, humi_q, humi_d;
  logic        flag_q, flag_d;
  logic        crc_ok;
  logic [15:0] word;

  always_comb begin
    pos_eff = (frame_start_i || (pos_q > POS_HUMI_CRC)) ? POS_TEMP_HI : pos_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    crc_d   = crc_q;
    temp_d  = temp_q;
    humi_d  = humi_q;
    flag_d  = flag_q;
    done_o  = 1'b0;
    crc_ok  = (crc_q == rx_byte_i);
    word    = {hi_q, lo_q};
    case (pos_eff)
      POS_TEMP_HI, POS_HUMI_HI: begin
        crc_d = crc8_feed(CRC_INIT, rx_byte_i);
        hi_d  = rx_byte_i;
      end
      POS_TEMP_LO, POS_HUMI_LO: begin
        crc_d = crc8_feed(crc_q, rx_byte_i);
        lo_d  = rx_byte_i;
      end
      POS_TEMP_CRC: begin
        if (crc_ok) begin
          temp_d = word;
        end
        flag_d = crc_ok;
        crc_d  = CRC_INIT;
      end
      POS_HUMI_CRC: begin
        if (crc_ok) begin
          humi_d = word;
        end
        crc_d  = CRC_INIT;
        done_o = 1'b1;
      end
      default: ;
    endcase
    pos_d = (pos_eff == POS_HUMI_CRC) ? POS_TEMP_HI : pos_eff + 3'd1;

    result_o.temp_ticks = temp_d;
    result_o.humi_ticks = humi_d;
    result_o.temp_ok    = flag_q;
    result_o.humi_ok    = crc_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_TEMP_HI;
      hi_q   <= '0;
      lo_q   <= '0;
      crc_q  <= CRC_INIT;
      temp_q <= '0;
      humi_q <= '0;
      flag_q <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      crc_q  <= crc_d;
      temp_q <= temp_d;
      humi_q <= humi_d;
      flag_q <= flag_d;
    end
  end

endmodule

/* sv/htfc_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_scale
// Converts raw sensor ticks to centi-degrees and centi-percent.
// ----------------------------------------------------------------------------
module htfc_scale (
  input  logic [15:0]        temp_ticks_i,
  input  logic [15:0]        humi_ticks_i,
  output logic signed [14:0] temp_centi_o,
  output logic signed [14:0] humi_centi_o
);
  import htfc_pkg::*;

  logic [30:0] temp_prod, humi_prod;
  logic [16:0] temp_diff, humi_diff;

  always_comb begin
    temp_prod    = 31'(temp_ticks_i) * 31'(TEMP_SCALE);
    humi_prod    = 31'(humi_ticks_i) * 31'(HUMI_SCALE);
    // upper product bits stay below 2^15, so one spare bit carries the sign
    temp_diff    = {2'b00, temp_prod[30:16]} - TEMP_OFFSET;
    humi_diff    = {2'b00, humi_prod[30:16]} - HUMI_OFFSET;
    temp_centi_o = signed'(temp_diff[14:0]);
    humi_centi_o = signed'(humi_diff[14:0]);
  end

endmodule

/* sv/humidity_temp_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// Checks six-byte humidity/temperature sensor frames and converts the words.
// ----------------------------------------------------------------------------
// Each request carries one response byte. A frame is temperature high, low,
// crc, then humidity high, low, crc; the crc is crc-8, polynomial 0x31, init
// 0xFF, msb first over the two word bytes. A word is stored only when its crc
// matches, otherwise the last good word is kept. After the sixth byte one
// result request leaves with temperature in 0.01 degC, humidity in 0.01 %RH
// and a pass flag per word. frame_start restarts the position and drops a
// partial frame. One byte is taken every clock cycle unless the input stalls:
// a byte is held in the input register, then crc, word update and the constant
// multiplies run in a single pass into the result register, so a result is
// offered from the result register once its sixth byte has left the input
// register. The input side stalls only while a finished result is held by
// out_stall_i and the held byte would close another frame.
// ----------------------------------------------------------------------------
module humidity_temp_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] temperature_centi_o,
  output logic signed [14:0] humidity_centi_o,
  output logic               temp_word_ok_o,
  output logic               humi_word_ok_o
);
  import htfc_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;

  // result register
  logic               out_valid_q;
  logic signed [14:0] temp_q, humi_q;
  logic               temp_ok_q, humi_ok_q;

  logic               done;
  logic               advance;
  logic               in_take;
  htfc_result_t       result;
  logic signed [14:0] temp_centi, humi_centi;

  // the held byte moves on unless it closes a frame while a result waits
  assign advance    = in_valid_q && (!done || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  // crc check and word storage
  htfc_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .rx_byte_i     (byte_q),
    .frame_start_i (start_q),
    .done_o        (done),
    .result_o      (result)
  );

  // tick to physical unit conversion
  htfc_scale u_scale (
    .temp_ticks_i (result.temp_ticks),
    .humi_ticks_i (result.humi_ticks),
    .temp_centi_o (temp_centi),
    .humi_centi_o (humi_centi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && done) begin
      temp_q    <= temp_centi;
      humi_q    <= humi_centi;
      temp_ok_q <= result.temp_ok;
      humi_ok_q <= result.humi_ok;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = humi_q;
  assign temp_word_ok_o      = temp_ok_q;
  assign humi_word_ok_o      = humi_ok_q;

`ifndef ASSERT_OFF
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done && out_valid_q) |-> !out_stall_i)
    else $error("result register overwritten while stalled");

  // a new result only comes from a frame-closing byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && done))
    else $error("result without a closing byte");

  // input stalls only while a byte is held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && done && out_valid_q))
    else $error("input stalled without cause");
`endif

endmodule
